// ===== design/srt_pkg.sv =====
// ============================================================================
// srt_pkg
// Shared types and constants for the insertion sorter: word layouts of the
// two channels, the cell operation codes and the link between neighbor cells.
// ============================================================================
package srt_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEPTH_DEFAULT = 16;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Input word: one element of a batch
    typedef struct packed {
        value_t value;
        logic   final_req;
    } in_word_t;

    // Output word: one element of the sorted run
    typedef struct packed {
        value_t sorted_value;
        logic   end_of_run;
        logic   overflow;
    } out_word_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        value_t   new_value;
    } cell_ctrl_t;

    // What a cell shows to its neighbors
    typedef struct packed {
        value_t value;
        logic   valid;
        logic   gt;
    } cell_link_t;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

// ===== design/srt_stream_if.sv =====
// ============================================================================
// srt_stream_if
// Valid/ready channel carrying one word of a packed payload type.
// ============================================================================
interface srt_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== design/srt_cell.sv =====
// ============================================================================
// srt_cell
// One place of the sorted chain. On insert it keeps its entry, takes the
// entry of its lower neighbor or takes the new value; on shift it takes the
// entry of its upper neighbor.
// ============================================================================
module srt_cell import srt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t lower,
    input  cell_link_t upper,
    output cell_link_t link
);

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;
    logic   gt;

    // An empty place counts as larger than any value
    assign gt = !valid_reg || (value_reg > ctrl.new_value);

    // Pick the next entry of this place
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (gt)
                begin
                    value_next = lower.gt ? lower.value : ctrl.new_value;
                    valid_next = valid_reg | lower.valid;
                end
            end
            OP_SHIFT:
            begin
                value_next = upper.value;
                valid_next = upper.valid;
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Hold the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.valid = valid_reg;
    assign link.gt    = gt;

endmodule

// ===== design/insertion_sorter_top.sv =====
// ============================================================================
// insertion_sorter_top
// Stable insertion sorter for batches of signed 32-bit values.
//
// Channels: items (sink) takes one value per word, final_req marks the last
// word of a batch. results (source) gives the stored values in ascending
// order, end_of_run on the largest, overflow on every word of a batch that
// held more than DEPTH values (the extra values are dropped).
// Throughput: while a batch is being collected, one input word per cycle;
// the chain of DEPTH cells compares and shifts in parallel.
// Output: the first result is valid in the cycle after the final word is
// accepted; the run then leaves at one word per cycle while the receiver
// takes each word, the chain shifting one place per result taken.
// No input word is taken while a run is being emptied.
// Reset: the store is empty and the overflow mark clear.
// Receiver stall: the lowest cell holds its word and the chain holds still.
// ============================================================================
module insertion_sorter_top import srt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    srt_stream_if.sink   items,
    srt_stream_if.source results
);

    state_t     state_reg;
    state_t     state_next;
    logic       dropped_reg;
    logic       dropped_next;
    cell_ctrl_t ctrl;
    cell_link_t links [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic       in_fire;
    logic       out_fire;
    logic       full;
    logic       last_word;
    in_word_t   in_word;
    out_word_t  out_word;

    assign in_word  = items.payload;
    assign full     = cell_valid[DEPTH-1];
    assign last_word = !cell_valid[1];

    assign items.ready   = (state_reg == ST_IDLE);
    assign results.valid = (state_reg == ST_DRAIN);
    assign in_fire       = items.valid && items.ready;
    assign out_fire      = results.valid && results.ready;

    // Drive the chain: insert on a stored word, shift down on a taken result
    always_comb
    begin
        ctrl.new_value = in_word.value;
        if (in_fire && !full)
        begin
            ctrl.op = OP_INSERT;
        end
        else if (out_fire)
        begin
            ctrl.op = OP_SHIFT;
        end
        else
        begin
            ctrl.op = OP_HOLD;
        end
    end

    // Row of cells, each linked to its neighbors; the end cells see fixed links
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_link_t lower;
            cell_link_t upper;
            if (i == 0)
            begin : g_bottom
                assign lower = '{value: '0, valid: 1'b1, gt: 1'b0};
            end
            else
            begin : g_lower
                assign lower = links[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_top
                assign upper = '{value: '0, valid: 1'b0, gt: 1'b0};
            end
            else
            begin : g_upper
                assign upper = links[i+1];
            end
            srt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .lower (lower),
                .upper (upper),
                .link  (links[i])
            );
            assign cell_valid[i] = links[i].valid;
        end
    endgenerate

    // Advance between collecting and emptying
    always_comb
    begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    dropped_next = dropped_reg | full;
                    if (in_word.final_req)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire && last_word)
                begin
                    state_next   = ST_IDLE;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next   = ST_IDLE;
                dropped_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    // Present the lowest cell as the result word
    assign out_word.sorted_value = links[0].value;
    assign out_word.end_of_run   = last_word;
    assign out_word.overflow     = dropped_reg;
    assign results.payload       = out_word;

    // Valid places always form a contiguous run from the bottom
    a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("chain valid bits are not contiguous");

    // A run being emptied always has a word in the lowest cell
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("draining with an empty chain");

    // Taking the last word leaves the chain empty and the block idle
    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_word) |=> (state_reg == ST_IDLE) && (cell_valid == '0)
            && !dropped_reg)
        else $error("chain not empty after end of run");

    // A final word always starts a drain
    a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_word.final_req) |=> (state_reg == ST_DRAIN))
        else $error("final word did not start a drain");

endmodule
